/* rtl/epsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsf_pkg
// Types, codes and pixel maps shared by the e-paper stream formatter.
// ----------------------------------------------------------------------------
package epsf_pkg;

    typedef enum logic [2:0] {
        KIND_SINGLE = 3'd0,
        KIND_PAIR   = 3'd1,
        KIND_LINE   = 3'd2,
        KIND_EXPAND = 3'd3,
        KIND_NIB    = 3'd4
    } kind_t;

    // One queued request: what the back end has to emit.
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  first_step;
        logic [15:0] word;
    } job_t;

    localparam logic       REG_PIXEL_MODE = 1'b0;
    localparam logic       REG_INVERT     = 1'b1;

    localparam logic [2:0] MODE_PASS   = 3'd0;
    localparam logic [2:0] MODE_COMPL  = 3'd1;
    localparam logic [2:0] MODE_GRAY   = 3'd2;
    localparam logic [2:0] MODE_LINE   = 3'd3;
    localparam logic [2:0] MODE_EXPAND = 3'd4;
    localparam logic [2:0] MODE_NIB    = 3'd5;

    localparam logic [3:0] STEP_WINDOW = 4'd0;
    localparam logic [3:0] STEP_HEADER = 4'd8;
    localparam logic [3:0] STEP_DATA   = 4'd14;

    localparam logic [7:0] CMD_WIN_X     = 8'h44;
    localparam logic [7:0] CMD_WIN_Y     = 8'h45;
    localparam logic [7:0] CMD_CNT_X     = 8'h4E;
    localparam logic [7:0] CMD_CNT_Y     = 8'h4F;
    localparam logic [7:0] CMD_WRITE_RAM = 8'h24;
    localparam logic [7:0] WIN_X_END     = 8'd15;
    localparam logic [7:0] WIN_Y_END     = 8'd249;
    localparam logic [7:0] ROW_LIMIT     = 8'd250;
    localparam logic [3:0] COL_LAST      = 4'd15;
    localparam logic [7:0] EXP_HI        = 8'h30;
    localparam logic [7:0] EXP_LO        = 8'h03;

    function automatic logic [1:0] gray_map(input logic [1:0] p);
        logic [1:0] r;
        case (p)
            2'd0:    r = 2'd0;
            2'd1:    r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] nib_map(input logic [1:0] p);
        logic [3:0] r;
        case (p)
            2'd1:    r = 4'd3;
            2'd3:    r = 4'd4;
            default: r = {2'b00, p};
        endcase
        return r;
    endfunction

    function automatic logic [3:0] last_step(input kind_t k);
        logic [3:0] r;
        case (k)
            KIND_PAIR:   r = 4'd1;
            KIND_NIB:    r = 4'd1;
            KIND_EXPAND: r = 4'd3;
            KIND_LINE:   r = STEP_DATA;
            default:     r = 4'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/epsf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsf_front
// Accepts image bytes, tracks pairing and line state, queues emit requests.
// ----------------------------------------------------------------------------
module epsf_front
    import epsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [2:0] pixel_mode,
    input  wire logic       invert_bits,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] pixel_byte,
    input  wire logic       frame_start,
    input  wire logic       push_ready,
    output logic            push_valid,
    output job_t            push_job
);

    logic [3:0]  col_reg, col_next, col_eff;
    logic [7:0]  row_reg, row_next, row_eff, row_inc;
    logic        exh_reg, exh_next, exh_eff;
    logic        pend_reg, pend_next, pend_eff;
    logic [7:0]  held_reg, held_next;
    logic        accept;
    logic [7:0]  pass_byte;
    logic [15:0] pair_word;
    logic [15:0] gray_word;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    assign col_eff  = frame_start ? 4'd0 : col_reg;
    assign row_eff  = frame_start ? 8'd0 : row_reg;
    assign exh_eff  = frame_start ? 1'b0 : exh_reg;
    assign pend_eff = frame_start ? 1'b0 : pend_reg;
    assign row_inc  = row_eff + 8'd1;

    assign pass_byte = invert_bits ? ~pixel_byte : pixel_byte;
    assign pair_word = {pixel_byte, held_reg};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            gray_word[15 - 2 * i -: 2] = gray_map(pair_word[2 * i +: 2]);
        end
    end

    always_comb
    begin
        col_next            = col_reg;
        row_next            = row_reg;
        exh_next            = exh_reg;
        pend_next           = pend_reg;
        held_next           = held_reg;
        push_valid          = 1'b0;
        push_job.kind       = KIND_SINGLE;
        push_job.first_step = 4'd0;
        push_job.word       = {8'd0, pixel_byte};
        if (accept)
        begin
            col_next  = col_eff;
            row_next  = row_eff;
            exh_next  = exh_eff;
            pend_next = pend_eff;
            case (pixel_mode)
                MODE_PASS:
                begin
                    push_valid    = 1'b1;
                    push_job.word = {8'd0, pass_byte};
                end
                MODE_COMPL:
                begin
                    push_valid    = 1'b1;
                    push_job.word = {8'd0, ~pass_byte};
                end
                MODE_GRAY:
                begin
                    if (!pend_eff)
                    begin
                        held_next = pixel_byte;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next     = 1'b0;
                        push_valid    = 1'b1;
                        push_job.kind = KIND_PAIR;
                        push_job.word = gray_word;
                    end
                end
                MODE_LINE:
                begin
                    push_job.kind = KIND_LINE;
                    push_job.word = {row_eff, pixel_byte};
                    if (frame_start)
                    begin
                        push_job.first_step = STEP_WINDOW;
                    end
                    else if (col_eff == 4'd0)
                    begin
                        push_job.first_step = STEP_HEADER;
                    end
                    else
                    begin
                        push_job.first_step = STEP_DATA;
                    end
                    if (!exh_eff)
                    begin
                        push_valid = 1'b1;
                        if (col_eff == COL_LAST)
                        begin
                            col_next = 4'd0;
                            row_next = row_inc;
                            if (row_inc > ROW_LIMIT)
                            begin
                                exh_next = 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_eff + 4'd1;
                        end
                    end
                end
                MODE_EXPAND:
                begin
                    push_valid    = 1'b1;
                    push_job.kind = KIND_EXPAND;
                end
                MODE_NIB:
                begin
                    push_valid    = 1'b1;
                    push_job.kind = KIND_NIB;
                    push_job.word = {nib_map(pixel_byte[1:0]), nib_map(pixel_byte[3:2]),
                                     nib_map(pixel_byte[5:4]), nib_map(pixel_byte[7:6])};
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= 4'd0;
            row_reg  <= 8'd0;
            exh_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            exh_reg  <= exh_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule
`default_nettype wire

/* rtl/epsf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsf_queue
// Small request queue between front and back ends.
// ----------------------------------------------------------------------------
module epsf_queue
    import epsf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  job_t      push_job,
    output logic      push_ready,
    output logic      head_valid,
    output job_t      head_job,
    input  wire logic pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

/* rtl/epsf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsf_back
// Walks each request into the output register at one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module epsf_back
    import epsf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic       is_data,
    output logic [7:0] panel_byte,
    output logic       run_last
);

    logic       out_valid_reg;
    logic       is_data_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       started_reg, started_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] step;
    logic       last;
    logic       load;
    logic       cur_data;
    logic [7:0] cur_byte;
    logic [1:0] pr;

    assign step = started_reg ? step_reg : head_job.first_step;
    assign last = (step == last_step(head_job.kind));
    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && last;

    always_comb
    begin
        case (step[1:0])
            2'd0:    pr = head_job.word[7:6];
            2'd1:    pr = head_job.word[5:4];
            2'd2:    pr = head_job.word[3:2];
            default: pr = head_job.word[1:0];
        endcase
    end

    always_comb
    begin
        cur_data = 1'b1;
        cur_byte = head_job.word[7:0];
        case (head_job.kind)
            KIND_PAIR, KIND_NIB:
            begin
                cur_byte = step[0] ? head_job.word[7:0] : head_job.word[15:8];
            end
            KIND_EXPAND:
            begin
                cur_byte = (pr[1] ? EXP_HI : 8'd0) | (pr[0] ? EXP_LO : 8'd0);
            end
            KIND_LINE:
            begin
                case (step)
                    4'd0:
                    begin
                        cur_data = 1'b0;
                        cur_byte = CMD_WIN_X;
                    end
                    4'd2:    cur_byte = WIN_X_END;
                    4'd3:
                    begin
                        cur_data = 1'b0;
                        cur_byte = CMD_WIN_Y;
                    end
                    4'd6:    cur_byte = WIN_Y_END;
                    4'd8:
                    begin
                        cur_data = 1'b0;
                        cur_byte = CMD_CNT_X;
                    end
                    4'd10:
                    begin
                        cur_data = 1'b0;
                        cur_byte = CMD_CNT_Y;
                    end
                    4'd11:   cur_byte = head_job.word[15:8];
                    4'd13:
                    begin
                        cur_data = 1'b0;
                        cur_byte = CMD_WRITE_RAM;
                    end
                    STEP_DATA: cur_byte = head_job.word[7:0];
                    default: cur_byte = 8'd0;
                endcase
            end
            default:
            begin
                cur_byte = head_job.word[7:0];
            end
        endcase
    end

    always_comb
    begin
        started_next = started_reg;
        step_next    = step_reg;
        if (load)
        begin
            started_next = !last;
            step_next    = step + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            step_reg      <= 4'd0;
        end
        else
        begin
            started_reg <= started_next;
            step_reg    <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_data_reg <= cur_data;
            byte_reg    <= cur_byte;
            last_reg    <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_data    = is_data_reg;
    assign panel_byte = byte_reg;
    assign run_last   = last_reg;

endmodule
`default_nettype wire

/* rtl/epaper_pixel_stream_formatter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epaper_pixel_stream_formatter
// Turns a stream of packed image bytes into tagged panel command/data bytes.
// ----------------------------------------------------------------------------
// Panel bytes leave at one per cycle while out_ready is high. An input byte
// causes 1 panel byte in pass and complement modes, 2 per pair in gray mode
// and 2 in two-bit mode, 4 in one-bit expand mode, 1, 7 or 15 in
// line-addressed mode (data only, line header, frame window plus header). The
// output byte sequencer walks each request through those bytes. A request
// queue of QUEUE_DEPTH entries lets the input side run ahead of the output.
// Write pixel_mode and invert_bits only while idle; the block does not check.
module epaper_pixel_stream_formatter
    import epsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] pixel_byte,
    input  wire logic       frame_start,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            is_data,
    output logic [7:0]      panel_byte,
    output logic            run_last
);

    logic [2:0] mode_reg;
    logic       invert_reg;
    logic       push_valid;
    logic       push_ready;
    job_t       push_job;
    logic       head_valid;
    job_t       head_job;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PASS;
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_MODE: mode_reg   <= cfg_data;
                REG_INVERT:     invert_reg <= cfg_data[0];
                default:        mode_reg   <= mode_reg;
            endcase
        end
    end

    epsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_mode  (mode_reg),
        .invert_bits (invert_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    epsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    epsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_data    (is_data),
        .panel_byte (panel_byte),
        .run_last   (run_last)
    );

endmodule
`default_nettype wire

/* rtl/epsf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsf_checker
// Port-level checks for the e-paper stream formatter.
// ----------------------------------------------------------------------------
module epsf_checker
    import epsf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       is_data,
    input wire logic [7:0] panel_byte,
    input wire logic       run_last
);

    // stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(panel_byte) && $stable(is_data) && $stable(run_last))
        else $error("output payload changed while stalled");

    // a run always closes on a data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |-> !run_last)
        else $error("command byte closes a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |->
            (panel_byte == CMD_WIN_X) || (panel_byte == CMD_WIN_Y) ||
            (panel_byte == CMD_CNT_X) || (panel_byte == CMD_CNT_Y) ||
            (panel_byte == CMD_WRITE_RAM))
        else $error("unknown command byte");

endmodule

bind epaper_pixel_stream_formatter epsf_checker u_epsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_data    (is_data),
    .panel_byte (panel_byte),
    .run_last   (run_last)
);
`default_nettype wire
